// File: rtl/hmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_pkg
// Shared types and constants for the histogram mode mean block.
// ----------------------------------------------------------------------------
package hmm_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BKT_W   = 8;
    localparam int unsigned VOTE_W  = 16;
    localparam int unsigned DROP_W  = 16;
    localparam int unsigned SUM_W   = 64;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD_RNG = 2'd2;

    localparam logic REG_MIN = 1'b0;
    localparam logic REG_MAX = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] mode_mean;
        logic [BKT_W-1:0]          winning_bucket;
        logic [VOTE_W-1:0]         winning_votes;
        logic [DROP_W-1:0]         dropped_count;
        logic [1:0]                result_status;
    } t_out_item;

    // Classified item handed from front to back.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      drop;
        logic                      last;
        logic                      bad_range;
        logic [VALUE_W:0]          offset;
        logic [VALUE_W:0]          span;
    } t_cls_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_UPD,
        BK_SCAN,
        BK_MDIV,
        BK_OUT,
        BK_CLR
    } t_bk_state;

endpackage
`default_nettype wire

// File: rtl/hmm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_front
// Range check and offset/span computation for each incoming item.
// ----------------------------------------------------------------------------
module hmm_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire hmm_pkg::t_in_item          i_item,
    input  wire logic signed [31:0]         i_min,
    input  wire logic signed [31:0]         i_max,
    output logic                            o_valid,
    output hmm_pkg::t_cls_item              o_cls
);

    logic               r_valid;
    hmm_pkg::t_cls_item r_cls;
    hmm_pkg::t_cls_item n_cls;
    logic signed [32:0] w_off;
    logic signed [32:0] w_span;

    always_comb begin
        w_off  = 33'(i_item.sample_value) - 33'(i_min);
        w_span = 33'(i_max) - 33'(i_min);
        n_cls.value     = i_item.sample_value;
        n_cls.last      = i_item.last_sample;
        n_cls.bad_range = (i_max <= i_min);
        n_cls.drop      = n_cls.bad_range || (i_item.sample_value < i_min)
                          || (i_item.sample_value > i_max);
        n_cls.offset    = w_off;
        n_cls.span      = w_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_cls <= n_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule
`default_nettype wire

// File: rtl/hmm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module hmm_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire hmm_pkg::t_cls_item  i_data,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic [1:0]               o_count,
    output hmm_pkg::t_cls_item       o_data
);

    hmm_pkg::t_cls_item r_mem [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_empty = (r_cnt == 2'd0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];

endmodule
`default_nettype wire

// File: rtl/hmm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hmm_div #(
    parameter int unsigned W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic              o_done,
    output logic [W-1:0]      o_quo
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[W-1]};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo;

endmodule
`default_nettype wire

// File: rtl/hmm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_back
// Bucket index divide, count/sum update, closing scan, mean divide, output, clear.
// ----------------------------------------------------------------------------
module hmm_back #(
    parameter int unsigned BUCKETS    = 30,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_avail,
    input  wire hmm_pkg::t_cls_item  i_cls,
    output logic                     o_pop,
    output logic                     o_busy,
    output logic                     o_strobe,
    output hmm_pkg::t_out_item       o_result
);

    localparam int unsigned BI   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int unsigned SW   = hmm_pkg::SUM_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    hmm_pkg::t_bk_state r_st;
    hmm_pkg::t_bk_state n_st;

    logic [COUNT_BITS-1:0] r_cnt [BUCKETS];
    logic signed [SW-1:0]  r_sum [BUCKETS];
    logic [hmm_pkg::DROP_W-1:0] r_drop;

    hmm_pkg::t_cls_item    r_cur;
    logic [BI-1:0]         r_idx;
    logic [BI-1:0]         r_best;
    logic [COUNT_BITS-1:0] r_bv;
    logic                  r_mneg;

    logic          w_dstart;
    logic [SW-1:0] w_num;
    logic [SW-1:0] w_den;
    logic          w_ddone;
    logic [SW-1:0] w_quo;
    logic [BI-1:0] w_qidx;
    logic [SW-1:0] w_abs;
    logic [SW-1:0] w_mean;
    logic [hmm_pkg::DROP_W-1:0] w_drop_n;

    hmm_div #(.W(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_abs = r_sum[r_best][SW-1] ? SW'(-r_sum[r_best]) : SW'(r_sum[r_best]);
        w_mean = r_mneg ? SW'(-w_quo) : w_quo;
        w_qidx = (w_quo >= SW'(BUCKETS)) ? BI'(BUCKETS - 1) : BI'(w_quo);
        w_drop_n = (r_drop == '1) ? r_drop : r_drop + hmm_pkg::DROP_W'(1);
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            hmm_pkg::BK_IDLE: if (i_avail) begin
                if (i_cls.drop) n_st = i_cls.last ? hmm_pkg::BK_SCAN : hmm_pkg::BK_IDLE;
                else n_st = hmm_pkg::BK_DIV;
            end
            hmm_pkg::BK_DIV:  if (w_ddone) n_st = hmm_pkg::BK_UPD;
            hmm_pkg::BK_UPD:  n_st = r_cur.last ? hmm_pkg::BK_SCAN : hmm_pkg::BK_IDLE;
            hmm_pkg::BK_SCAN: begin
                if (r_cur.bad_range || r_idx == BI'(BUCKETS - 1)) begin
                    n_st = (r_cur.bad_range || r_bv == '0 && r_cnt[r_idx] == '0)
                           ? hmm_pkg::BK_OUT : hmm_pkg::BK_MDIV;
                end
            end
            hmm_pkg::BK_MDIV: if (w_ddone) n_st = hmm_pkg::BK_OUT;
            hmm_pkg::BK_OUT:  n_st = hmm_pkg::BK_CLR;
            hmm_pkg::BK_CLR:  n_st = hmm_pkg::BK_IDLE;
            default:          n_st = hmm_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_st == hmm_pkg::BK_IDLE) && i_avail;
        o_busy   = (r_st != hmm_pkg::BK_IDLE);
        w_dstart = 1'b0;
        w_num    = '0;
        w_den    = '0;
        if (o_pop && !i_cls.drop) begin
            w_dstart = 1'b1;
            w_num    = SW'(i_cls.offset) * SW'(BUCKETS);
            w_den    = SW'(i_cls.span);
        end else if (r_st == hmm_pkg::BK_SCAN && n_st == hmm_pkg::BK_MDIV) begin
            w_dstart = 1'b1;
        end
        if (r_st == hmm_pkg::BK_SCAN) begin
            w_num = w_abs;
            w_den = SW'(r_bv);
            if (r_cnt[r_idx] > r_bv) begin
                w_num = r_sum[r_idx][SW-1] ? SW'(-r_sum[r_idx]) : SW'(r_sum[r_idx]);
                w_den = SW'(r_cnt[r_idx]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= hmm_pkg::BK_IDLE;
            r_drop <= '0;
            o_strobe <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_cnt[b] <= '0;
                r_sum[b] <= '0;
            end
        end else begin
            r_st     <= n_st;
            o_strobe <= 1'b0;
            if (o_pop && i_cls.drop) r_drop <= w_drop_n;
            if (r_st == hmm_pkg::BK_UPD && r_cnt[r_idx] != CMAX) begin
                r_cnt[r_idx] <= r_cnt[r_idx] + COUNT_BITS'(1);
                r_sum[r_idx] <= r_sum[r_idx] + SW'(r_cur.value);
            end
            if (r_st == hmm_pkg::BK_OUT) o_strobe <= 1'b1;
            if (r_st == hmm_pkg::BK_CLR) begin
                r_drop <= '0;
                for (int b = 0; b < BUCKETS; b++) begin
                    r_cnt[b] <= '0;
                    r_sum[b] <= '0;
                end
            end
        end
        if (o_pop) begin
            r_cur <= i_cls;
            r_idx <= '0;
            r_bv  <= '0;
            r_best <= '0;
        end
        if (r_st == hmm_pkg::BK_DIV && w_ddone) r_idx <= w_qidx;
        if (r_st == hmm_pkg::BK_UPD) begin
            r_idx <= '0;
            r_bv  <= '0;
            r_best <= '0;
        end
        if (r_st == hmm_pkg::BK_SCAN) begin
            if (r_cnt[r_idx] > r_bv) begin
                r_bv   <= r_cnt[r_idx];
                r_best <= r_idx;
                r_mneg <= r_sum[r_idx][SW-1];
            end
            if (r_idx != BI'(BUCKETS - 1)) r_idx <= r_idx + BI'(1);
        end
        if (r_st == hmm_pkg::BK_OUT) begin
            o_result.dropped_count <= r_drop;
            if (r_cur.bad_range) begin
                o_result.result_status  <= hmm_pkg::ST_BAD_RNG;
                o_result.mode_mean      <= '0;
                o_result.winning_bucket <= '0;
                o_result.winning_votes  <= '0;
            end else if (r_bv == '0) begin
                o_result.result_status  <= hmm_pkg::ST_EMPTY;
                o_result.mode_mean      <= '0;
                o_result.winning_bucket <= '0;
                o_result.winning_votes  <= '0;
            end else begin
                o_result.result_status  <= hmm_pkg::ST_OK;
                o_result.mode_mean      <= w_mean[31:0];
                o_result.winning_bucket <= 8'(r_best);
                o_result.winning_votes  <= (COUNT_BITS > 16 && 33'(r_bv) > 33'd65535)
                                           ? 16'hFFFF : 16'(r_bv);
            end
        end
    end

    ap_strobe_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_st) == hmm_pkg::BK_OUT)
        else $error("strobe without close");
    ap_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> r_drop == '0)
        else $error("drop tally not cleared");
    ap_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !o_busy)
        else $error("pop while busy");

endmodule
`default_nettype wire

// File: rtl/histogram_mode_mean.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_mode_mean
// Histogram mode estimate: bins values, picks fullest bucket, emits its mean.
// ----------------------------------------------------------------------------
// Binned item: 64-bit serial index divide plus count/sum update.
// Out-of-range item: dropped in the back end with no divide. Last item adds a
// scan over all buckets, a mean divide, and then output and store clear.
// busy holds off start while the queue holds an item or the front end has one in flight.
// Synchronous active-low reset clears all buckets and the dropped tally.
// Results are a one-cycle strobe; the receiver cannot stall.
module histogram_mode_mean #(
    parameter int unsigned BUCKETS    = 30,
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire hmm_pkg::t_in_item  i_item,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_strobe,
    output hmm_pkg::t_out_item      o_result
);

    logic signed [31:0] r_min;
    logic signed [31:0] r_max;
    logic               w_acc;
    logic               w_fv;
    hmm_pkg::t_cls_item w_fcls;
    logic               w_pop;
    logic               w_empty;
    logic [1:0]         w_cnt;
    hmm_pkg::t_cls_item w_qd;
    logic               w_bbusy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= 32'sd65536;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hmm_pkg::REG_MIN) r_min <= i_cfg_data;
            else r_max <= i_cfg_data;
        end
    end

    assign busy  = (w_cnt != 2'd0) || w_fv;
    assign w_acc = start && !busy;

    hmm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_item  (i_item),
        .i_min   (r_min),
        .i_max   (r_max),
        .o_valid (w_fv),
        .o_cls   (w_fcls)
    );

    hmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fv),
        .i_data  (w_fcls),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_count (w_cnt),
        .o_data  (w_qd)
    );

    hmm_back #(.BUCKETS(BUCKETS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!w_empty),
        .i_cls    (w_qd),
        .o_pop    (w_pop),
        .o_busy   (w_bbusy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> busy)
        else $error("accept did not raise busy");
    ap_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty && !w_bbusy)
        else $error("pop from empty queue");
    ap_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt != 2'd3)
        else $error("queue overflow");

endmodule
`default_nettype wire
